// ===== hw/rtl/nlsc_pkg.sv =====
// Package: constants and types for the Newton line-search step controller.
`default_nettype none

package nlsc_pkg;

   // Field widths fixed by the transaction format
   localparam int unsigned RES_PORT_BITS  = 32;
   localparam int unsigned ITER_BITS      = 16;
   localparam int unsigned EXP_BITS       = 6;
   localparam int unsigned TRIAL_BITS     = 6;
   localparam int unsigned GOOD_BITS      = 3;
   localparam int unsigned STAG_BITS      = 2;
   localparam int unsigned REQ_DATA_BITS  = 48;
   localparam int unsigned RSP_DATA_BITS  = 40;

   // Default number of residual bits that take part in the tests
   localparam int unsigned RESIDUAL_BITS_DEFAULT = 32;

   // Step exponent limits
   localparam logic [EXP_BITS-1:0] EXP_LIMIT    = 6'd50;
   localparam logic [EXP_BITS-1:0] EXP_NEAR_MIN = 6'd34;
   localparam logic [EXP_BITS-1:0] EXP_HALVE_MAX = 6'd1;

   // Counter limits
   localparam logic [TRIAL_BITS-1:0] TRIAL_MAX  = 6'd63;
   localparam logic [GOOD_BITS-1:0]  GOOD_MAX   = 3'd7;
   localparam logic [GOOD_BITS-1:0]  GOOD_GIVEUP = 3'd5;
   localparam logic [STAG_BITS-1:0]  STAG_MAX   = 2'd3;
   localparam logic [ITER_BITS-1:0]  ITER_RESET_MAX = 16'd1;

   // Ratio test multipliers (a * p < b * q)
   localparam int unsigned ACC_R_MUL  = 10;   // accept: 10 r < 9 first
   localparam int unsigned ACC_F_MUL  = 9;
   localparam int unsigned FB_F_MUL   = 10;   // fallback seen: r < 10 first
   localparam int unsigned REF_R_MUL  = 2;    // refine: 2 r < ratio
   localparam int unsigned REF_F_MUL  = 11;   // refine: 11 first < 10 r
   localparam int unsigned REF_R2_MUL = 10;
   localparam int unsigned PRG_B_MUL  = 100;  // progress: 100 best < 99 first
   localparam int unsigned PRG_F_MUL  = 99;
   localparam int unsigned STL_B_MUL  = 1000; // stall: 1000 best >= 999 first
   localparam int unsigned STL_F_MUL  = 999;
   localparam int unsigned MUL_EXTRA_BITS = 10;

   // Request kind carried in tuser
   typedef enum logic {
      CMD_START = 1'b0,
      CMD_EVAL  = 1'b1
   } cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/newton_line_search_control_top.sv =====
// Top level: step-length controller for a backtracking Newton line search.
//
// Usage:
//  - Request channel (req_*): one transaction per command. tuser is the command
//    (start a search, or report the residual of the step last proposed); tdata
//    carries the residual and, for a start, the Newton iteration number.
//  - Response channel (rsp_*): exactly one transaction per request. tuser is
//    the done flag; tdata gives the step exponent (step = 2^-e) and, when done,
//    the residual of the accepted step.
//  - Pipeline: an accepted request sits in the input register; the result
//    register loads from it once that register is free, and the response is
//    valid from then until it is taken.
//  - Throughput: one request per cycle unless the receiver stalls. Search
//    state updates as the result register loads; the next request sees it.
//  - Stall: when rsp_tready is low the result is held; the input register still
//    takes one more request, after which req_tready drops until the result
//    leaves.
//  - Reset (synchronous, active high): clears both registers' valid flags and
//    all search state, including the stagnation counter kept across searches.
`default_nettype none

module newton_line_search_control_top
   import nlsc_pkg::*;
#(
   parameter int unsigned RESIDUAL_BITS = RESIDUAL_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // Request channel
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,  // residual[31:0], global_iteration[47:32]
   input  wire logic                     req_tuser,  // cmd
   // Response channel
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,  // step_exponent[5:0], best_residual[37:6], 0
   output logic                          rsp_tuser   // done_res
);

   // Residual bits used internally; the port carries at most 32
   localparam int unsigned RW = (RESIDUAL_BITS < RES_PORT_BITS) ? RESIDUAL_BITS : RES_PORT_BITS;
   localparam int unsigned MW = RW + MUL_EXTRA_BITS;

   // Input register
   logic                 s_valid_ff;
   cmd_type              s_cmd_ff;
   logic [RW-1:0]        s_res_ff;
   logic [ITER_BITS-1:0] s_iter_ff;

   // Result register
   logic                 rsp_valid_ff;
   logic                 rsp_done_ff, rsp_done_in;
   logic [EXP_BITS-1:0]  rsp_exp_ff, rsp_exp_in;
   logic [RES_PORT_BITS-1:0] rsp_best_ff, rsp_best_in;

   // Search state
   logic [RW-1:0]         first_ff, first_in;
   logic [RW-1:0]         best_ff, best_in;
   logic [EXP_BITS-1:0]   best_exp_ff, best_exp_in;
   logic [EXP_BITS-1:0]   tried_ff, tried_in;
   logic [EXP_BITS-1:0]   next_ff, next_in;
   logic [TRIAL_BITS-1:0] trial_ff, trial_in;
   logic [GOOD_BITS-1:0]  good_ff, good_in;
   logic [STAG_BITS-1:0]  stag_ff, stag_in;
   logic                  seen_ff, seen_in;
   logic [RW-1:0]         ratio_res_ff, ratio_res_in;
   logic [EXP_BITS-1:0]   ratio_exp_ff, ratio_exp_in;
   logic [TRIAL_BITS-1:0] ratio_trial_ff, ratio_trial_in;

   // Evaluate path intermediates
   logic                  out_free, s_fire;
   logic                  upd_ratio, seen1;
   logic [RW-1:0]         ratio_res1, best1, best2;
   logic [EXP_BITS-1:0]   best_exp1, best_exp2;
   logic [GOOD_BITS-1:0]  good1, good2;
   logic [STAG_BITS-1:0]  stag1, stag2;
   logic                  accept, give_up;
   logic [TRIAL_BITS-1:0] trial_inc;
   logic [EXP_BITS-1:0]   next_step;

   // Handshake: the input register moves on when the result register is free
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s_fire     = s_valid_ff && out_free;
   assign req_tready = !s_valid_ff || out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_done_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - RES_PORT_BITS - EXP_BITS){1'b0}},
                        rsp_best_ff, rsp_exp_ff};

   // Proposal of the next step from the current state
   assign trial_inc = (trial_ff < TRIAL_MAX) ? trial_ff + 1'b1 : trial_ff;
   always_comb begin
      next_step = next_ff + ((next_ff <= EXP_HALVE_MAX) ? 6'd1 : 6'd2);
      if (next_step > EXP_LIMIT) begin
         next_step = EXP_LIMIT;
      end
   end

   // Decision logic for one transaction
   always_comb begin
      first_in       = first_ff;
      best_in        = best_ff;
      best_exp_in    = best_exp_ff;
      tried_in       = tried_ff;
      next_in        = next_ff;
      trial_in       = trial_ff;
      good_in        = good_ff;
      stag_in        = stag_ff;
      seen_in        = seen_ff;
      ratio_res_in   = ratio_res_ff;
      ratio_exp_in   = ratio_exp_ff;
      ratio_trial_in = ratio_trial_ff;
      rsp_done_in    = 1'b0;
      rsp_exp_in     = '0;
      rsp_best_in    = '0;

      // Fallback step: first below ten times the start, or a refinement of it
      upd_ratio = (!seen_ff && (MW'(s_res_ff) < MW'(first_ff) * MW'(FB_F_MUL))) ||
                  (seen_ff &&
                   (MW'(s_res_ff) * MW'(REF_R_MUL) < MW'(ratio_res_ff)) &&
                   (MW'(first_ff) * MW'(REF_F_MUL) < MW'(s_res_ff) * MW'(REF_R2_MUL)) &&
                   ({1'b0, trial_ff} <= {1'b0, ratio_trial_ff} + 7'd1));
      seen1      = seen_ff || upd_ratio;
      ratio_res1 = upd_ratio ? s_res_ff : ratio_res_ff;

      // Best step so far and improvement count
      if (good_ff == '0 || s_res_ff < best_ff) begin
         best1     = s_res_ff;
         best_exp1 = tried_ff;
         good1     = 3'd1;
      end else begin
         best1     = best_ff;
         best_exp1 = best_exp_ff;
         good1     = good_ff;
      end
      good2 = (best1 < first_ff && good1 < GOOD_MAX) ? good1 + 1'b1 : good1;

      accept  = MW'(s_res_ff) * MW'(ACC_R_MUL) < MW'(first_ff) * MW'(ACC_F_MUL);
      give_up = (good2 >= GOOD_GIVEUP) || (next_ff >= EXP_NEAR_MIN && seen1) ||
                (next_ff >= EXP_LIMIT);

      // Give-up path: stagnation bookkeeping and fallback substitution
      stag1 = (MW'(best1) * MW'(PRG_B_MUL) < MW'(first_ff) * MW'(PRG_F_MUL)) ? '0 : stag_ff;
      if (stag1 >= STAG_MAX) begin
         best2     = ratio_res1;
         best_exp2 = upd_ratio ? tried_ff : ratio_exp_ff;
      end else begin
         best2     = best1;
         best_exp2 = best_exp1;
      end
      stag2 = (!(MW'(best2) * MW'(STL_B_MUL) < MW'(first_ff) * MW'(STL_F_MUL)) &&
               stag1 < STAG_MAX) ? stag1 + 1'b1 : stag1;

      if (s_cmd_ff == CMD_START) begin
         // Open a search and propose the full step
         if (s_iter_ff <= ITER_RESET_MAX) begin
            stag_in = '0;
         end
         first_in    = s_res_ff;
         best_in     = s_res_ff;
         best_exp_in = '0;
         tried_in    = '0;
         trial_in    = 6'd1;
         next_in     = 6'd1;
         good_in     = '0;
         seen_in     = 1'b0;
         rsp_exp_in  = '0;
      end else begin
         seen_in = seen1;
         if (upd_ratio) begin
            ratio_res_in   = s_res_ff;
            ratio_exp_in   = tried_ff;
            ratio_trial_in = trial_ff;
         end
         good_in = good2;
         if (accept) begin
            best_in     = best1;
            best_exp_in = best_exp1;
            stag_in     = '0;
            rsp_done_in = 1'b1;
            rsp_exp_in  = best_exp1;
            rsp_best_in = RES_PORT_BITS'(best1);
         end else if (give_up) begin
            best_in     = best2;
            best_exp_in = best_exp2;
            stag_in     = stag2;
            rsp_done_in = 1'b1;
            rsp_exp_in  = best_exp2;
            rsp_best_in = RES_PORT_BITS'(best2);
         end else begin
            best_in     = best1;
            best_exp_in = best_exp1;
            tried_in    = next_ff;
            trial_in    = trial_inc;
            next_in     = next_step;
            rsp_exp_in  = next_ff;
         end
      end
   end

   // Control registers and search state
   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         first_ff       <= '0;
         best_ff        <= '0;
         best_exp_ff    <= '0;
         tried_ff       <= '0;
         next_ff        <= '0;
         trial_ff       <= '0;
         good_ff        <= '0;
         stag_ff        <= '0;
         seen_ff        <= 1'b0;
         ratio_res_ff   <= '0;
         ratio_exp_ff   <= '0;
         ratio_trial_ff <= '0;
      end else begin
         if (req_tready) begin
            s_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            rsp_valid_ff <= s_valid_ff;
         end
         if (s_fire) begin
            first_ff       <= first_in;
            best_ff        <= best_in;
            best_exp_ff    <= best_exp_in;
            tried_ff       <= tried_in;
            next_ff        <= next_in;
            trial_ff       <= trial_in;
            good_ff        <= good_in;
            stag_ff        <= stag_in;
            seen_ff        <= seen_in;
            ratio_res_ff   <= ratio_res_in;
            ratio_exp_ff   <= ratio_exp_in;
            ratio_trial_ff <= ratio_trial_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s_cmd_ff  <= cmd_type'(req_tuser);
         s_res_ff  <= req_tdata[RW-1:0];
         s_iter_ff <= req_tdata[RES_PORT_BITS +: ITER_BITS];
      end
      if (s_fire) begin
         rsp_done_ff <= rsp_done_in;
         rsp_exp_ff  <= rsp_exp_in;
         rsp_best_ff <= rsp_best_in;
      end
   end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the Newton line-search step-length controller.
module testbench;
   import nlsc_pkg::*;

   localparam int CLOCK_HALF    = 5;
   localparam int RESET_CYCLES  = 12;
   localparam int DRAIN_CYCLES  = 8;
   localparam int HOLD_CYCLES   = 300;     // long receiver stall
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_LIMIT  = 10;

   // Step exponent and counter limits of the search
   localparam logic [5:0] STEP_EXP_CAP    = 6'd50;
   localparam logic [5:0] STEP_EXP_GIVEUP = 6'd34;
   localparam logic [5:0] TRIALS_CAP      = 6'd63;
   localparam logic [2:0] GOOD_CAP        = 3'd7;
   localparam logic [2:0] GOOD_GIVEUP     = 3'd5;
   localparam logic [1:0] STALL_CAP       = 2'd3;

   typedef struct packed {
      logic       done;
      logic [5:0] exponent;
      logic [31:0] best;
   } step_result_type;

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #CLOCK_HALF clock = ~clock;

   // DUT connections
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;   // residual[31:0], global_iteration[47:32]
   logic                     req_tuser  = CMD_START;  // cmd
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;   // step_exponent[5:0], best_residual[37:6], 0
   logic                     rsp_tuser;   // done_res

   newton_line_search_control_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Search state mirrored by the predictor
   logic [31:0] srch_first    = '0;
   logic [31:0] srch_best     = '0;
   logic [5:0]  srch_best_exp = '0;
   logic [5:0]  srch_tried    = '0;
   logic [5:0]  srch_next     = '0;
   logic [5:0]  srch_trials   = '0;
   logic [2:0]  srch_good     = '0;
   logic [1:0]  stall_searches = '0;
   logic        fb_valid      = 1'b0;
   logic [31:0] fb_res        = '0;
   logic [5:0]  fb_exp        = '0;
   logic [5:0]  fb_trials     = '0;

   step_result_type expected_steps[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic hold_active = 1'b0;
   int hold_count    = 0;
   int item_count    = 0;
   int rsp_count     = 0;
   int fail_count    = 0;
   int cycle_count   = 0;

   // exact test a * p < b * q
   function automatic logic scaled_below(logic [31:0] a, int unsigned p,
                                         logic [31:0] b, int unsigned q);
      logic [63:0] lhs, rhs;
      lhs = {32'b0, a} * 64'(p);
      rhs = {32'b0, b} * 64'(q);
      return lhs < rhs;
   endfunction

   // hand out the next step: halve while e <= 1, quarter after that
   function automatic logic [5:0] next_step_exponent();
      logic [6:0] e;
      srch_tried = srch_next;
      if (srch_trials < TRIALS_CAP) srch_trials = srch_trials + 6'd1;
      e = {1'b0, srch_next} + ((srch_next <= 6'd1) ? 7'd1 : 7'd2);
      if (e > {1'b0, STEP_EXP_CAP}) e = {1'b0, STEP_EXP_CAP};
      srch_next = e[5:0];
      return srch_tried;
   endfunction

   // advance the search state by one request and return its response
   function automatic step_result_type line_search_step(cmd_type cmd, logic [31:0] r,
                                                        logic [15:0] iter);
      step_result_type res;
      logic done;
      res = '0;
      done = 1'b0;
      if (cmd == CMD_START) begin
         if (iter <= 16'd1) stall_searches = '0;
         srch_first = r;
         srch_best = r;
         srch_best_exp = '0;
         srch_tried = '0;
         srch_next = '0;
         srch_trials = '0;
         srch_good = '0;
         fb_valid = 1'b0;
         res.exponent = next_step_exponent();
         return res;
      end
      // fallback: first step below ten times the start, then refined
      if (!fb_valid && scaled_below(r, 1, srch_first, 10)) begin
         fb_res = r;
         fb_exp = srch_tried;
         fb_trials = srch_trials;
         fb_valid = 1'b1;
      end
      if (fb_valid && scaled_below(r, 2, fb_res, 1) && scaled_below(srch_first, 11, r, 10)
          && int'(srch_trials) <= int'(fb_trials) + 1) begin
         fb_res = r;
         fb_exp = srch_tried;
         fb_trials = srch_trials;
      end
      if (srch_good == '0 || r < srch_best) begin
         srch_best = r;
         srch_best_exp = srch_tried;
         srch_good = 3'd1;
      end
      if (srch_best < srch_first && srch_good < GOOD_CAP) srch_good = srch_good + 3'd1;

      if (scaled_below(r, 10, srch_first, 9)) begin
         stall_searches = '0;
         done = 1'b1;
      end else if (srch_good >= GOOD_GIVEUP || (srch_next >= STEP_EXP_GIVEUP && fb_valid)
                   || srch_next >= STEP_EXP_CAP) begin
         if (scaled_below(srch_best, 100, srch_first, 99)) stall_searches = '0;
         if (stall_searches >= STALL_CAP) begin
            srch_best = fb_res;
            srch_best_exp = fb_exp;
         end
         if (!scaled_below(srch_best, 1000, srch_first, 999) && stall_searches < STALL_CAP)
            stall_searches = stall_searches + 2'd1;
         done = 1'b1;
      end

      res.done = done;
      if (done) begin
         res.exponent = srch_best_exp;
         res.best = srch_best;
      end else begin
         res.exponent = next_step_exponent();
      end
      return res;
   endfunction

   // residual at a given permille band of the start residual, saturated
   function automatic logic [31:0] pick_residual(logic [31:0] first, int band);
      logic [63:0] r;
      int unsigned pm;
      case (band)
         0:       pm = $urandom_range(899, 0);
         1:       pm = $urandom_range(989, 900);
         2:       pm = $urandom_range(1000, 990);
         3:       pm = $urandom_range(1100, 1001);
         4:       pm = $urandom_range(9999, 1101);
         5:       pm = $urandom_range(100000, 10000);
         default: return $urandom;
      endcase
      r = {32'b0, first} * 64'(pm) / 64'd1000;
      return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
   endtask

   // send one request transaction and queue its expected response
   task automatic send_request(input cmd_type cmd, input logic [31:0] res,
                               input logic [15:0] iter, output logic done);
      step_result_type want;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {iter, res};
      do @(posedge clock); while (!req_tready);
      want = line_search_step(cmd, res, iter);
      expected_steps.push_back(want);
      item_count++;
      done = want.done;
   endtask

   // lower valid and wait for every expected response, then the pipeline latency
   task automatic drain;
      req_tvalid <= 1'b0;
      while (expected_steps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one search: start, then evaluations mostly from one residual band
   task automatic run_search(input logic [31:0] first, input logic [15:0] iter,
                             input int band, input int stray_pct);
      logic done;
      int evals;
      int b;
      send_request(CMD_START, first, iter, done);
      evals = 0;
      while (!done && evals < 64) begin
         b = ($urandom_range(99) < 80) ? band : $urandom_range(6);
         send_request(CMD_EVAL, pick_residual(first, b), 16'($urandom), done);
         evals++;
         // abandoned search: a new start comes before the end
         if ($urandom_range(99) < stray_pct) break;
      end
      // evaluation after the search has ended
      if (done && $urandom_range(99) < stray_pct)
         send_request(CMD_EVAL, $urandom, 16'($urandom), done);
   endtask

   task automatic test_eval_before_start;
      logic done;
      send_request(CMD_EVAL, 32'd0, 16'd0, done);
      send_request(CMD_EVAL, 32'hFFFF_FFFF, 16'hFFFF, done);
      send_request(CMD_EVAL, $urandom, 16'($urandom), done);
   endtask

   // zero start residual never sees a fallback: three stalled searches, then
   // the fourth takes the fallback registers still at their reset value
   task automatic test_stale_fallback;
      for (int k = 0; k < 4; k++) run_search(32'd0, 16'd2 + 16'(k), 6, 0);
   endtask

   task automatic test_field_extremes;
      logic done;
      send_request(CMD_START, 32'hFFFF_FFFF, 16'hFFFF, done);
      send_request(CMD_EVAL, 32'hFFFF_FFFF, 16'hFFFF, done);
      send_request(CMD_EVAL, 32'd0, 16'd0, done);
      send_request(CMD_START, 32'd0, 16'd0, done);
      send_request(CMD_EVAL, 32'd0, 16'd0, done);
      send_request(CMD_START, 32'd1, 16'd1, done);
      send_request(CMD_EVAL, 32'd0, 16'd0, done);
   endtask

   // accept threshold sits exactly at nine tenths of the start residual
   task automatic test_accept_threshold;
      logic done;
      send_request(CMD_START, 32'd1000, 16'd2, done);
      send_request(CMD_EVAL, 32'd900, 16'd0, done);
      send_request(CMD_EVAL, 32'd899, 16'd0, done);
   endtask

   task automatic test_give_up;
      logic done;
      // stalled searches: the fourth replaces the best step by the fallback
      for (int k = 0; k < 4; k++) begin
         send_request(CMD_START, 32'd1_000_000, 16'd3, done);
         send_request(CMD_EVAL, 32'd999_800, 16'd0, done);
         while (!done) send_request(CMD_EVAL, 32'd999_500, 16'd0, done);
      end
      // progress below 0.99 of the start clears the stagnation count
      send_request(CMD_START, 32'd1_000_000, 16'd4, done);
      while (!done) send_request(CMD_EVAL, 32'd985_000, 16'd0, done);
      // above the start but below ten times it: refined fallback, give-up near 2^-34
      send_request(CMD_START, 32'd1000, 16'd0, done);
      send_request(CMD_EVAL, 32'd9000, 16'd0, done);
      send_request(CMD_EVAL, 32'd4000, 16'd0, done);
      while (!done) send_request(CMD_EVAL, 32'd3000, 16'd0, done);
      send_request(CMD_EVAL, 32'd500, 16'd0, done);
   endtask

   task automatic test_random_searches(input int n_items);
      int stop_at;
      logic [31:0] first;
      logic [15:0] iter;
      stop_at = item_count + n_items;
      while (item_count < stop_at) begin
         case ($urandom_range(9))
            0:       first = $urandom_range(20);
            1:       first = 32'hFFFF_FFFF;
            default: first = $urandom >> $urandom_range(31);
         endcase
         case ($urandom_range(9))
            0, 1:    iter = 16'($urandom_range(1));
            2:       iter = 16'($urandom);
            default: iter = 16'($urandom_range(9, 2));
         endcase
         run_search(first, iter, $urandom_range(6), 5);
      end
   endtask

   // receiver stops for a long stretch while requests keep coming
   task automatic test_backpressure;
      hold_active <= 1'b1;
      test_random_searches(40);
      drain;
      hold_active <= 1'b0;
   endtask

   // long stall counter
   always @(posedge clock) begin
      if (hold_active) begin
         if (hold_count < HOLD_CYCLES) hold_count <= hold_count + 1;
      end else begin
         hold_count <= 0;
      end
   end

   // receiver ready
   always @(posedge clock) begin
      rsp_tready <= !(hold_active && hold_count < HOLD_CYCLES)
                    && ($urandom_range(99) >= recv_idle_pct);
   end

   // response checker
   always @(posedge clock) begin : check_responses
      step_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_steps.size() == 0) begin
            note_failure($sformatf("response %0d with none expected", rsp_count));
         end else begin
            want = expected_steps.pop_front();
            if (rsp_tuser !== want.done || rsp_tdata[5:0] !== want.exponent
                || rsp_tdata[37:6] !== want.best || rsp_tdata[39:38] !== 2'b00)
               note_failure($sformatf(
                  {"response %0d: expected done=%0b exp=%0d best=%h, ",
                   "got done=%0b exp=%0d best=%h pad=%b"},
                  rsp_count, want.done, want.exponent, want.best,
                  rsp_tuser, rsp_tdata[5:0], rsp_tdata[37:6], rsp_tdata[39:38]));
         end
         rsp_count++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** newton_line_search_control_top: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver heavily
      send_idle_pct = 27;
      recv_idle_pct <= 82;
      test_eval_before_start;
      test_stale_fallback;
      test_field_extremes;
      test_accept_threshold;
      test_give_up;
      test_random_searches(330);
      drain;

      // the other way round
      send_idle_pct = 82;
      recv_idle_pct <= 27;
      test_random_searches(330);
      drain;

      // no idling on either side
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      test_backpressure;
      test_random_searches(270);
      drain;

      if (fail_count == 0 && expected_steps.size() == 0) begin
         $display("** newton_line_search_control_top: PASSED **");
      end else begin
         $display("** newton_line_search_control_top: FAILED **");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/nlsc_pkg.sv
hw/rtl/newton_line_search_control_top.sv
sim/testbench.sv
